@@ hdl/bve_pkg.sv @@
package bve_pkg;

    // Field widths of the request and response channels
    localparam int REQ_W   = 3;
    localparam int POS_W   = 8;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    // Default sizing
    localparam int DEPTH_DEFAULT         = 256;
    localparam int WORD_WIDTH_DEFAULT    = 32;
    localparam int INIT_CAPACITY_DEFAULT = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

    // Response status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ hdl/bounded_vector_engine.sv @@
// Bounded vector engine: a vector of words kept in an on-chip memory of
// DEPTH entries, with an entry count and a logical capacity.
// Request channel (in_valid/in_ready): req_type, position, item_word.
// Response channel (out_valid/out_ready): status, read_word, entry_count,
// logical_capacity; one response per request, in request order.
// Push, pop, set, invalid codes and any failed request answer from the
// output register in the cycle after the request transfers; get waits in
// ST_GET for the registered memory read; delete at index p moves the
// entries above p one slot lower in ST_SHIFT, one entry per cycle through
// the single read and write port, and answers when the loop ends.
// One request is in work at a time; a new request is taken in the cycle
// its predecessor's response transfers, so push/pop/set sustain one
// request per cycle when out_ready stays high; get and delete block until they answer.
// A stalled response holds in the output register and blocks new requests.
// Reset clears the count to zero and the capacity to INIT_CAPACITY; memory
// contents are not cleared, since only written entries are ever read.
module bounded_vector_engine #(
    parameter int DEPTH         = bve_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH    = bve_pkg::WORD_WIDTH_DEFAULT,
    parameter int INIT_CAPACITY = bve_pkg::INIT_CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bve_pkg::REQ_W-1:0]   req_type,
    input  logic [bve_pkg::POS_W-1:0]   position,
    input  logic [bve_pkg::DATA_W-1:0]  item_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bve_pkg::STAT_W-1:0]  status,
    output logic [bve_pkg::DATA_W-1:0]  read_word,
    output logic [bve_pkg::COUNT_W-1:0] entry_count,
    output logic [bve_pkg::COUNT_W-1:0] logical_capacity
);

    localparam int MAX_VAL = (DEPTH > INIT_CAPACITY) ? DEPTH : INIT_CAPACITY;
    localparam int W       = $clog2(MAX_VAL + 1);
    localparam int PW      = (W > bve_pkg::POS_W) ? W : bve_pkg::POS_W;
    localparam int AW      = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_GET   = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [W-1:0]  count_reg, count_next;
    logic [W-1:0]  cap_reg, cap_next;
    logic [W-1:0]  sh_reg, sh_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          pend_reg, pend_next;

    logic                        out_valid_reg, out_valid_next;
    logic [bve_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [bve_pkg::DATA_W-1:0]  read_word_reg, read_word_next;
    logic [bve_pkg::COUNT_W-1:0] ocount_reg, ocount_next;
    logic [bve_pkg::COUNT_W-1:0] ocap_reg, ocap_next;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_wdata;

    logic          in_fire;
    logic          idx_ok;
    logic [W-1:0]  count_dec;
    logic [W:0]    cap_grown;
    logic [W-1:0]  sh_prev;

    // Halve the capacity when the new count is nonzero and a quarter of it
    function automatic logic [W-1:0] shrink_cap(input logic [W-1:0] cnt,
                                                 input logic [W-1:0] cap);
        logic [W-1:0] res;
        res = cap;
        if ((cnt != '0) && (cnt == (cap >> 2)))
        begin
            res = cap >> 1;
        end
        return res;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign idx_ok    = PW'(position) < PW'(count_reg);
    assign count_dec = count_reg - 1'b1;
    assign cap_grown = {1'b0, cap_reg} << 1;
    assign sh_prev   = sh_reg - 1'b1;

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign read_word        = read_word_reg;
    assign entry_count      = ocount_reg;
    assign logical_capacity = ocap_reg;

    always_comb
    begin
        logic                       load_v;
        logic [bve_pkg::STAT_W-1:0] st_v;
        logic [bve_pkg::DATA_W-1:0] rw_v;

        load_v         = 1'b0;
        st_v           = bve_pkg::STAT_OK;
        rw_v           = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        sh_next        = sh_reg;
        wr_addr_next   = wr_addr_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        read_word_next = read_word_reg;
        ocount_next    = ocount_reg;
        ocap_next      = ocap_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(position);
        mem_wdata      = WORD_WIDTH'(item_word);
        mem_raddr      = AW'(position);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    load_v = 1'b1;
                    case (req_type)
                        bve_pkg::REQ_PUSH:
                        begin
                            mem_waddr = count_reg[AW-1:0];
                            if (count_reg >= W'(DEPTH))
                            begin
                                st_v = bve_pkg::STAT_FULL;
                            end
                            else if (count_reg >= cap_reg)
                            begin
                                if (cap_grown > (W+1)'(DEPTH))
                                begin
                                    st_v = bve_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    cap_next   = cap_grown[W-1:0];
                                    mem_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bve_pkg::REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                st_v = bve_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                count_next = count_dec;
                                cap_next   = shrink_cap(count_dec, cap_reg);
                            end
                        end
                        bve_pkg::REQ_SET:
                        begin
                            if (idx_ok)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                st_v = bve_pkg::STAT_RANGE;
                            end
                        end
                        bve_pkg::REQ_GET:
                        begin
                            if (idx_ok)
                            begin
                                load_v     = 1'b0;
                                state_next = ST_GET;
                            end
                            else
                            begin
                                st_v = bve_pkg::STAT_RANGE;
                            end
                        end
                        bve_pkg::REQ_DELETE:
                        begin
                            if (idx_ok)
                            begin
                                load_v     = 1'b0;
                                state_next = ST_SHIFT;
                                sh_next    = W'(position) + 1'b1;
                            end
                            else
                            begin
                                st_v = bve_pkg::STAT_RANGE;
                            end
                        end
                        default:
                        begin
                            st_v = bve_pkg::STAT_RANGE;
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                load_v     = 1'b1;
                rw_v       = bve_pkg::DATA_W'(rd_data_reg);
                state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                // write back the word read in the previous cycle one slot lower
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (sh_reg != count_reg)
                begin
                    mem_raddr    = sh_reg[AW-1:0];
                    wr_addr_next = sh_prev[AW-1:0];
                    pend_next    = 1'b1;
                    sh_next      = sh_reg + 1'b1;
                end
                else
                begin
                    count_next = count_dec;
                    cap_next   = shrink_cap(count_dec, cap_reg);
                    load_v     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_v)
        begin
            out_valid_next = 1'b1;
            status_next    = st_v;
            read_word_next = rw_v;
            ocount_next    = bve_pkg::COUNT_W'(count_next);
            ocap_next      = bve_pkg::COUNT_W'(cap_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= W'(INIT_CAPACITY);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        wr_addr_reg   <= wr_addr_next;
        status_reg    <= status_next;
        read_word_reg <= read_word_next;
        ocount_reg    <= ocount_next;
        ocap_reg      <= ocap_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= W'(DEPTH)) && (count_reg <= cap_reg))
        else $error("entry count exceeds depth or capacity");

    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (sh_reg <= count_reg) && (sh_reg != '0))
        else $error("shift pointer out of range");

    a_cap_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cap_reg == $past(cap_reg)) || (cap_reg == ($past(cap_reg) << 1))
                 || (cap_reg == ($past(cap_reg) >> 1)))
        else $error("capacity changed by other than doubling or halving");

    a_no_write_in_get: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GET) |-> !mem_we && !out_valid_reg)
        else $error("memory write or pending response during get");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import bve_pkg::*;

    localparam int VEC_DEPTH = DEPTH_DEFAULT;

    // Request codes the block does not define; each must come back as a range error
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} load_phase_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  read_word;
        logic [COUNT_W-1:0] entry_count;
        logic [COUNT_W-1:0] logical_capacity;
    } vec_resp_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        bit                typed;
        vec_resp_t         want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type = '0;
    logic [POS_W-1:0]     position = '0;
    logic [DATA_W-1:0]    item_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [DATA_W-1:0]    read_word;
    logic [COUNT_W-1:0]   entry_count;
    logic [COUNT_W-1:0]   logical_capacity;

    // Shadow copy of the vector state
    logic [DATA_W-1:0]    shadow_mem [VEC_DEPTH];
    logic [COUNT_W-1:0]   shadow_count;
    logic [COUNT_W-1:0]   shadow_cap;

    vec_resp_t            pending_resp [$];
    dir_row_t             dir_rows [$];
    int                   mismatch_count = 0;
    int                   issued_count = 0;
    int                   send_idle_pct = 22;
    int                   recv_idle_pct = 83;

    bounded_vector_engine u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .position         (position),
        .item_word        (item_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .read_word        (read_word),
        .entry_count      (entry_count),
        .logical_capacity (logical_capacity)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void shrink_check();
        if (shadow_count != 0 && shadow_count == shadow_cap / 4)
            shadow_cap = shadow_cap / 2;
    endfunction

    function automatic vec_resp_t vector_apply(input logic [REQ_W-1:0] req,
                                               input logic [POS_W-1:0] pos,
                                               input logic [DATA_W-1:0] word);
        vec_resp_t        r;
        logic [COUNT_W:0] grown;
        bit               in_range;
        r.status    = STAT_OK;
        r.read_word = '0;
        in_range    = ({1'b0, pos} < shadow_count);
        grown       = {shadow_cap, 1'b0};
        case (req)
            REQ_PUSH:
            begin
                if (shadow_count >= VEC_DEPTH)
                    r.status = STAT_FULL;
                else if (shadow_count >= shadow_cap && grown > VEC_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (shadow_count >= shadow_cap)
                        shadow_cap = grown[COUNT_W-1:0];
                    shadow_mem[shadow_count[POS_W-1:0]] = word;
                    shadow_count++;
                end
            end
            REQ_POP:
            begin
                if (shadow_count == 0)
                    r.status = STAT_RANGE;
                else
                begin
                    shadow_count--;
                    shrink_check();
                end
            end
            REQ_SET:
            begin
                if (in_range)
                    shadow_mem[pos] = word;
                else
                    r.status = STAT_RANGE;
            end
            REQ_GET:
            begin
                if (in_range)
                    r.read_word = shadow_mem[pos];
                else
                    r.status = STAT_RANGE;
            end
            REQ_DELETE:
            begin
                if (in_range)
                begin
                    // shift the tail down by one
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_mem[POS_W'(i)] = shadow_mem[POS_W'(i + 1)];
                    shadow_count--;
                    shrink_check();
                end
                else
                    r.status = STAT_RANGE;
            end
            default:
                r.status = STAT_RANGE;
        endcase
        r.entry_count      = shadow_count;
        r.logical_capacity = shadow_cap;
        return r;
    endfunction

    function automatic dir_row_t make_row(input logic [REQ_W-1:0] req,
                                          input logic [POS_W-1:0] pos,
                                          input logic [DATA_W-1:0] word,
                                          input bit typed,
                                          input logic [STAT_W-1:0] st,
                                          input logic [DATA_W-1:0] rd,
                                          input int cnt,
                                          input int cap);
        dir_row_t row;
        row.req                    = req;
        row.pos                    = pos;
        row.word                   = word;
        row.typed                  = typed;
        row.want.status            = st;
        row.want.read_word         = rd;
        row.want.entry_count       = cnt[COUNT_W-1:0];
        row.want.logical_capacity  = cap[COUNT_W-1:0];
        return row;
    endfunction

    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] word,
                                 input bit use_typed,
                                 input vec_resp_t typed_resp,
                                 output logic [STAT_W-1:0] predicted_status);
        vec_resp_t predicted;
        bit        took;
        predicted = vector_apply(req, pos, word);
        predicted_status = predicted.status;
        if (use_typed)
            predicted = typed_resp;
        if (issued_count < 300)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 83;
        end
        else if (issued_count < 600)
        begin
            send_idle_pct = 83;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        position  <= pos;
        item_word <= word;
        took = 1'b0;
        // ready is settled by the falling edge; the next rising edge is the transfer
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            if (took)
                pending_resp.push_back(predicted);
            @(posedge clk);
        end
        issued_count++;
    endtask

    task automatic run_phase(input load_phase_t ph, input int max_items);
        int                full_hits;
        int                empty_hits;
        int                roll;
        logic [REQ_W-1:0]  req;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        logic [STAT_W-1:0] st;
        vec_resp_t         unused_resp;
        full_hits  = 0;
        empty_hits = 0;
        unused_resp = '{default: '0};
        for (int n = 0; n < max_items; n++)
        begin
            if (ph == PH_FILL && full_hits >= 3)
                break;
            if (ph == PH_DRAIN && empty_hits >= 3)
                break;
            roll = $urandom_range(99);
            case (ph)
                PH_FILL:
                    req = (roll < 86) ? REQ_PUSH : (roll < 91) ? REQ_SET :
                          (roll < 96) ? REQ_GET : (roll < 97) ? REQ_POP :
                          (roll < 99) ? REQ_DELETE : REQ_RSVD5;
                PH_DRAIN:
                    req = (roll < 50) ? REQ_POP : (roll < 84) ? REQ_DELETE :
                          (roll < 90) ? REQ_GET : (roll < 95) ? REQ_SET :
                          (roll < 98) ? REQ_PUSH : REQ_RSVD5;
                default:
                    req = (roll < 30) ? REQ_PUSH : (roll < 45) ? REQ_POP :
                          (roll < 60) ? REQ_SET : (roll < 75) ? REQ_GET :
                          (roll < 97) ? REQ_DELETE : REQ_RSVD5;
            endcase
            if (req == REQ_RSVD5)
                req = req + REQ_W'($urandom_range(2));
            roll = $urandom_range(99);
            if (shadow_count != 0 && roll < 85)
                pos = POS_W'($urandom_range(shadow_count - 1));
            else if (roll < 90)
                pos = shadow_count[POS_W-1:0];
            else
                pos = POS_W'($urandom_range(255));
            roll = $urandom_range(99);
            word = (roll < 10) ? '0 : (roll < 20) ? '1 : DATA_W'($urandom);
            if (shadow_count == 0)
                empty_hits++;
            issue_request(req, pos, word, 1'b0, unused_resp, st);
            if (st == STAT_FULL)
                full_hits++;
        end
    endtask

    always @(negedge clk)
    begin : response_check
        vec_resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_resp.size() == 0)
                report_mismatch("response transfer with no request outstanding");
            else
            begin
                want = pending_resp.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (read_word !== want.read_word)
                    report_mismatch($sformatf("read_word got %08h want %08h",
                                              read_word, want.read_word));
                if (entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              entry_count, want.entry_count));
                if (logical_capacity !== want.logical_capacity)
                    report_mismatch($sformatf("logical_capacity got %0d want %0d",
                                              logical_capacity, want.logical_capacity));
            end
        end
    end

    initial
    begin : stimulus
        logic [STAT_W-1:0] st;
        shadow_count = '0;
        shadow_cap   = COUNT_W'(INIT_CAPACITY_DEFAULT);

        // empty vector: every access but push fails, unknown codes too
        dir_rows.push_back(make_row(REQ_POP, 0, 0, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_GET, 0, 0, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_SET, 0, 32'h1111_1111, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_DELETE, 0, 0, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_RSVD5, 0, 0, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_RSVD6, 8'h55, 0, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_RSVD7, 8'hff, 32'hffff_ffff, 1, STAT_RANGE, 0, 0, 5));
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'hffff_ffff, 1, STAT_OK, 0, 1, 5));
        dir_rows.push_back(make_row(REQ_PUSH, 8'hff, 32'h0000_0000, 1, STAT_OK, 0, 2, 5));
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'h1234_5678, 1, STAT_OK, 0, 3, 5));
        dir_rows.push_back(make_row(REQ_GET, 0, 0, 1, STAT_OK, 32'hffff_ffff, 3, 5));
        dir_rows.push_back(make_row(REQ_GET, 1, 0, 1, STAT_OK, 0, 3, 5));
        dir_rows.push_back(make_row(REQ_GET, 3, 0, 1, STAT_RANGE, 0, 3, 5));
        dir_rows.push_back(make_row(REQ_SET, 8'hff, 32'hffff_ffff, 1, STAT_RANGE, 0, 3, 5));
        dir_rows.push_back(make_row(REQ_SET, 1, 32'ha5a5_a5a5, 1, STAT_OK, 0, 3, 5));
        dir_rows.push_back(make_row(REQ_DELETE, 0, 0, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_GET, 0, 0, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_DELETE, 8'hff, 0, 1, STAT_RANGE, 0, 2, 5));
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'h5a5a_5a5a, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'h8000_0001, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'h7fff_fffe, 0, STAT_OK, 0, 0, 0));
        // full vector: capacity doubles before the store
        dir_rows.push_back(make_row(REQ_PUSH, 0, 32'hdead_beef, 1, STAT_OK, 0, 6, 10));
        dir_rows.push_back(make_row(REQ_DELETE, 5, 0, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_DELETE, 2, 0, 0, STAT_OK, 0, 0, 0));
        dir_rows.push_back(make_row(REQ_GET, 3, 0, 0, STAT_OK, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            issue_request(dir_rows[k].req, dir_rows[k].pos, dir_rows[k].word,
                          dir_rows[k].typed, dir_rows[k].want, st);

        // grow on the odd-capacity path until it saturates, drain to empty
        // (which drops onto the power-of-two path), then grow to the full store
        run_phase(PH_FILL, 800);
        run_phase(PH_DRAIN, 800);
        run_phase(PH_FILL, 900);
        run_phase(PH_MIXED, 120);
        in_valid <= 1'b0;

        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bve_pkg.sv
hdl/bounded_vector_engine.sv
bench/tb_top.sv
